/* design/sawc_pkg.sv */
// ----------------------------------------------------------------------------
// sawc_pkg: shared constants and types of the set-associative cache
// Geometry, opcodes, the classified item that passes from front to back,
// and the status groups that the top level watches.
// ----------------------------------------------------------------------------
`default_nettype none

package sawc_pkg;

  localparam int SET_COUNT = 16;
  localparam int WAY_COUNT = 4;
  localparam int MEM_WORDS = 1024;

  localparam int ADDR_W  = 12;
  localparam int LANE_W  = 2;
  localparam int WADDR_W = ADDR_W - LANE_W;
  localparam int SET_W   = $clog2(SET_COUNT);
  localparam int TAG_W   = WADDR_W - SET_W;
  localparam int MEM_AW  = $clog2(MEM_WORDS);
  localparam int WORD_W  = 32;
  localparam int BYTE_W  = 8;
  localparam int AGE_W   = 2;
  localparam int WAY_W   = 2;
  localparam int CNT_W   = 32;

  localparam int QDEPTH = 2;
  localparam int QPTR_W = 1;
  localparam int QCNT_W = 2;

  localparam logic [1:0] OP_READ    = 2'd0;
  localparam logic [1:0] OP_WRITE   = 2'd1;
  localparam logic [1:0] OP_PRELOAD = 2'd2;

  typedef enum logic [3:0] {
    KIND_READ    = 4'b0001,
    KIND_WRITE   = 4'b0010,
    KIND_PRELOAD = 4'b0100,
    KIND_NOP     = 4'b1000
  } kind_t;

  typedef struct packed {
    kind_t               kind;
    logic [ADDR_W-1:0]   address;
    logic [BYTE_W-1:0]   write_byte;
    logic [WORD_W-1:0]   preload_word;
  } item_t;

  typedef struct packed {
    logic [TAG_W-1:0]  tag;
    logic [WORD_W-1:0] word;
  } line_t;

  typedef struct packed {
    logic [QCNT_W-1:0] count;
  } front_stat_t;

  typedef struct packed {
    logic idle;
    logic lookup;
  } back_stat_t;

endpackage

`default_nettype wire

/* design/sawc_in_if.sv */
// ----------------------------------------------------------------------------
// sawc_in_if: request channel of the cache
// Valid/ready channel carrying one access or preload request per beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface sawc_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  opcode;
  logic [11:0] address;
  logic [7:0]  write_byte;
  logic [31:0] preload_word;

  modport source (output valid, output opcode, output address, output write_byte,
                  output preload_word, input ready);
  modport sink (input valid, input opcode, input address, input write_byte,
                input preload_word, output ready);
endinterface

`default_nettype wire

/* design/sawc_out_if.sv */
// ----------------------------------------------------------------------------
// sawc_out_if: response channel of the cache
// Valid/ready channel carrying one response per beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface sawc_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  read_byte;
  logic        was_hit;
  logic [31:0] hit_count;
  logic [31:0] miss_count;

  modport source (output valid, output read_byte, output was_hit, output hit_count,
                  output miss_count, input ready);
  modport sink (input valid, input read_byte, input was_hit, input hit_count,
                input miss_count, output ready);
endinterface

`default_nettype wire

/* design/sawc_ram.sv */
// ----------------------------------------------------------------------------
// sawc_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module sawc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

/* design/sawc_front.sv */
// ----------------------------------------------------------------------------
// sawc_front: request intake and classification
// Decodes each request beat into an item kind and holds it in a short queue.
// ----------------------------------------------------------------------------
`default_nettype none

module sawc_front (
  input  wire logic          clk,
  input  wire logic          rst_n,
  sawc_in_if.sink            in_ch,
  input  wire logic          q_pop,
  output logic               q_valid,
  output sawc_pkg::item_t    q_head,
  output sawc_pkg::front_stat_t stat
);

  sawc_pkg::item_t                   q_r [sawc_pkg::QDEPTH];
  logic [sawc_pkg::QPTR_W-1:0]       wr_ptr_r, wr_ptr_nxt;
  logic [sawc_pkg::QPTR_W-1:0]       rd_ptr_r, rd_ptr_nxt;
  logic [sawc_pkg::QCNT_W-1:0]       cnt_r, cnt_nxt;
  sawc_pkg::item_t                   item_in;
  logic                              push;

  always_comb begin
    item_in.address      = in_ch.address;
    item_in.write_byte   = in_ch.write_byte;
    item_in.preload_word = in_ch.preload_word;
    unique case (in_ch.opcode)
      sawc_pkg::OP_READ:    item_in.kind = sawc_pkg::KIND_READ;
      sawc_pkg::OP_WRITE:   item_in.kind = sawc_pkg::KIND_WRITE;
      sawc_pkg::OP_PRELOAD: item_in.kind = sawc_pkg::KIND_PRELOAD;
      default:              item_in.kind = sawc_pkg::KIND_NOP;
    endcase
  end

  assign in_ch.ready = (cnt_r != sawc_pkg::QCNT_W'(sawc_pkg::QDEPTH));
  assign push        = in_ch.valid && in_ch.ready;
  assign q_valid     = (cnt_r != '0);
  assign q_head      = q_r[rd_ptr_r];
  assign stat.count  = cnt_r;

  always_comb begin
    wr_ptr_nxt = push  ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = q_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push && !q_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (!push && q_pop) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= item_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

`default_nettype wire

/* design/sawc_back.sv */
// ----------------------------------------------------------------------------
// sawc_back: cache lookup, replacement and backing memory
// Reads a set, resolves hit or victim, writes back, fills and updates LRU.
// ----------------------------------------------------------------------------
`default_nettype none

module sawc_back (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          q_valid,
  input  sawc_pkg::item_t    q_head,
  output logic               q_pop,
  sawc_out_if.source         out_ch,
  output sawc_pkg::back_stat_t stat
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_LOOK = 2'b10
  } state_t;

  localparam int LW = sawc_pkg::TAG_W + sawc_pkg::WORD_W;

  state_t                              state_r, state_nxt;
  sawc_pkg::item_t                     item_r;
  logic [sawc_pkg::AGE_W-1:0]          lru_age_r [sawc_pkg::WAY_COUNT][sawc_pkg::SET_COUNT];
  logic                                valid_r   [sawc_pkg::WAY_COUNT][sawc_pkg::SET_COUNT];
  logic                                dirty_r   [sawc_pkg::WAY_COUNT][sawc_pkg::SET_COUNT];
  logic [sawc_pkg::CNT_W-1:0]          hit_cnt_r, hit_cnt_nxt;
  logic [sawc_pkg::CNT_W-1:0]          miss_cnt_r, miss_cnt_nxt;
  logic                                out_valid_r;
  logic [sawc_pkg::BYTE_W-1:0]         out_byte_r, out_byte_nxt;
  logic                                out_hit_r, out_hit_nxt;

  logic                                out_free;
  logic                                head_access;
  logic                                idle_commit;
  logic                                look_commit;
  logic                                ram_re;
  logic [sawc_pkg::SET_W-1:0]          rd_set;
  sawc_pkg::line_t                     way_rdata [sawc_pkg::WAY_COUNT];
  sawc_pkg::line_t                     way_wdata;
  logic [sawc_pkg::WORD_W-1:0]         mem_rdata;
  logic                                mem_we;
  logic [sawc_pkg::MEM_AW-1:0]         mem_waddr;
  logic [sawc_pkg::WORD_W-1:0]         mem_wdata;

  logic [sawc_pkg::SET_W-1:0]          set_idx;
  logic [sawc_pkg::TAG_W-1:0]          tag;
  logic [sawc_pkg::LANE_W-1:0]         lane;
  logic [sawc_pkg::MEM_AW-1:0]         fill_addr;
  logic [sawc_pkg::MEM_AW-1:0]         wb_addr;
  logic [sawc_pkg::WAY_COUNT-1:0]      hit_vec;
  logic                                hit_any;
  logic [sawc_pkg::WAY_W-1:0]          hit_way;
  logic [sawc_pkg::WAY_W-1:0]          victim;
  logic [sawc_pkg::WAY_W-1:0]          sel;
  logic                                victim_dirty;
  logic                                is_write;
  logic [sawc_pkg::WORD_W-1:0]         fill_word;
  logic [sawc_pkg::WORD_W-1:0]         base_word;
  logic [sawc_pkg::WORD_W-1:0]         new_word;
  logic [sawc_pkg::AGE_W-1:0]          sel_age;

  assign out_free    = !out_valid_r || out_ch.ready;
  assign head_access = (q_head.kind == sawc_pkg::KIND_READ) ||
                       (q_head.kind == sawc_pkg::KIND_WRITE);
  assign rd_set      = q_head.address[sawc_pkg::LANE_W +: sawc_pkg::SET_W];

  // Decode of the item under lookup
  assign set_idx   = item_r.address[sawc_pkg::LANE_W +: sawc_pkg::SET_W];
  assign tag       = item_r.address[sawc_pkg::LANE_W + sawc_pkg::SET_W +: sawc_pkg::TAG_W];
  assign lane      = item_r.address[sawc_pkg::LANE_W-1:0];
  assign fill_addr = sawc_pkg::MEM_AW'(item_r.address[sawc_pkg::ADDR_W-1:sawc_pkg::LANE_W]);
  assign is_write  = (item_r.kind == sawc_pkg::KIND_WRITE);

  always_comb begin
    for (int w = 0; w < sawc_pkg::WAY_COUNT; w++) begin
      hit_vec[w] = valid_r[w][set_idx] && (way_rdata[w].tag == tag);
    end
  end

  assign hit_any = |hit_vec;

  always_comb begin
    hit_way = '0;
    for (int w = sawc_pkg::WAY_COUNT - 1; w >= 0; w--) begin
      if (hit_vec[w]) begin
        hit_way = sawc_pkg::WAY_W'(w);
      end
    end
  end

  // Oldest way wins, the lowest index on a tie
  always_comb begin
    victim = '0;
    for (int w = 1; w < sawc_pkg::WAY_COUNT; w++) begin
      if (lru_age_r[victim][set_idx] < lru_age_r[w][set_idx]) begin
        victim = sawc_pkg::WAY_W'(w);
      end
    end
  end

  assign sel          = hit_any ? hit_way : victim;
  assign victim_dirty = !hit_any && dirty_r[victim][set_idx];
  assign wb_addr      = sawc_pkg::MEM_AW'({way_rdata[victim].tag, set_idx});
  assign sel_age      = lru_age_r[sel][set_idx];

  // A write-back that aliases the fill address supplies the fill data itself.
  assign fill_word = (victim_dirty && (wb_addr == fill_addr)) ?
                     way_rdata[victim].word : mem_rdata;
  assign base_word = hit_any ? way_rdata[sel].word : fill_word;

  always_comb begin
    new_word = base_word;
    if (is_write) begin
      new_word[lane*sawc_pkg::BYTE_W +: sawc_pkg::BYTE_W] = item_r.write_byte;
    end
  end

  assign way_wdata.tag  = tag;
  assign way_wdata.word = new_word;

  // Control
  always_comb begin
    state_nxt    = state_r;
    q_pop        = 1'b0;
    ram_re       = 1'b0;
    idle_commit  = 1'b0;
    look_commit  = 1'b0;
    hit_cnt_nxt  = hit_cnt_r;
    miss_cnt_nxt = miss_cnt_r;
    out_byte_nxt = '0;
    out_hit_nxt  = 1'b0;
    mem_we       = 1'b0;
    mem_waddr    = fill_addr;
    mem_wdata    = way_rdata[victim].word;
    unique case (state_r)
      ST_IDLE: begin
        if (q_valid && head_access) begin
          q_pop     = 1'b1;
          ram_re    = 1'b1;
          state_nxt = ST_LOOK;
        end else if (q_valid && out_free) begin
          q_pop       = 1'b1;
          idle_commit = 1'b1;
          if (q_head.kind == sawc_pkg::KIND_PRELOAD) begin
            mem_we    = 1'b1;
            mem_waddr = sawc_pkg::MEM_AW'(
                          q_head.address[sawc_pkg::ADDR_W-1:sawc_pkg::LANE_W]);
            mem_wdata = q_head.preload_word;
          end
        end
      end
      ST_LOOK: begin
        if (out_free) begin
          look_commit = 1'b1;
          state_nxt   = ST_IDLE;
          out_hit_nxt = hit_any;
          if (hit_any) begin
            hit_cnt_nxt = hit_cnt_r + 1'b1;
          end else begin
            miss_cnt_nxt = miss_cnt_r + 1'b1;
          end
          if (!is_write) begin
            out_byte_nxt = base_word[lane*sawc_pkg::BYTE_W +: sawc_pkg::BYTE_W];
          end
          if (victim_dirty) begin
            mem_we    = 1'b1;
            mem_waddr = wb_addr;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  for (genvar w = 0; w < sawc_pkg::WAY_COUNT; w++) begin : g_way
    sawc_ram #(.WIDTH(LW), .DEPTH(sawc_pkg::SET_COUNT)) u_line_ram (
      .clk   (clk),
      .we    (look_commit && (sel == sawc_pkg::WAY_W'(w)) && (!hit_any || is_write)),
      .waddr (set_idx),
      .wdata (way_wdata),
      .re    (ram_re),
      .raddr (rd_set),
      .rdata (way_rdata[w])
    );
  end

  sawc_ram #(.WIDTH(sawc_pkg::WORD_W), .DEPTH(sawc_pkg::MEM_WORDS)) u_backing_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (ram_re),
    .raddr (sawc_pkg::MEM_AW'(q_head.address[sawc_pkg::ADDR_W-1:sawc_pkg::LANE_W])),
    .rdata (mem_rdata)
  );

  always_ff @(posedge clk) begin
    if (q_pop) begin
      item_r <= q_head;
    end
    if (idle_commit || look_commit) begin
      out_byte_r <= out_byte_nxt;
      out_hit_r  <= out_hit_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      hit_cnt_r   <= '0;
      miss_cnt_r  <= '0;
      out_valid_r <= 1'b0;
      for (int w = 0; w < sawc_pkg::WAY_COUNT; w++) begin
        for (int s = 0; s < sawc_pkg::SET_COUNT; s++) begin
          lru_age_r[w][s] <= '1;
          valid_r[w][s]   <= 1'b0;
          dirty_r[w][s]   <= 1'b0;
        end
      end
    end else begin
      state_r    <= state_nxt;
      hit_cnt_r  <= hit_cnt_nxt;
      miss_cnt_r <= miss_cnt_nxt;
      if (idle_commit || look_commit) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      if (look_commit) begin
        valid_r[sel][set_idx] <= 1'b1;
        if (is_write) begin
          dirty_r[sel][set_idx] <= 1'b1;
        end else if (!hit_any) begin
          dirty_r[sel][set_idx] <= 1'b0;
        end
        for (int w = 0; w < sawc_pkg::WAY_COUNT; w++) begin
          if (sel == sawc_pkg::WAY_W'(w)) begin
            lru_age_r[w][set_idx] <= '0;
          end else if (lru_age_r[w][set_idx] < sel_age) begin
            lru_age_r[w][set_idx] <= lru_age_r[w][set_idx] + 1'b1;
          end
        end
      end
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.read_byte  = out_byte_r;
  assign out_ch.was_hit    = out_hit_r;
  assign out_ch.hit_count  = hit_cnt_r;
  assign out_ch.miss_count = miss_cnt_r;

  assign stat.idle   = (state_r == ST_IDLE);
  assign stat.lookup = (state_r == ST_LOOK);

endmodule

`default_nettype wire

/* design/set_assoc_writeback_cache_lru.sv */
// A read or write leaves the queue with a set read, then is resolved and
// updated in the lookup state, which registers its response beat; preload
// and unused opcodes commit straight from idle. No new item is taken until
// the access in lookup commits. Reset is synchronous and active low; it
// clears valid, dirty, counters and sets all LRU ages to three.
// ----------------------------------------------------------------------------
// set_assoc_writeback_cache_lru: four-way write-back byte cache with LRU
// A front stage decodes request beats into a two-entry queue; a back stage
// looks up the set, replaces the oldest way, writes back and fills.
// ----------------------------------------------------------------------------
`default_nettype none

module set_assoc_writeback_cache_lru (
  input  wire logic clk,
  input  wire logic rst_n,
  sawc_in_if.sink   in_ch,
  sawc_out_if.source out_ch
);

  // Queue head and pop pass from the front to the back. The front keeps
  // accepting beats while the back is busy with a lookup or waits on a stalled
  // response, until its queue is full.
  logic                  q_valid;
  logic                  q_pop;
  sawc_pkg::item_t       q_head;
  sawc_pkg::front_stat_t front_stat;
  sawc_pkg::back_stat_t  back_stat;

  sawc_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .q_pop   (q_pop),
    .q_valid (q_valid),
    .q_head  (q_head),
    .stat    (front_stat)
  );

  // The back stage holds the line tags and words in one RAM per way, the
  // valid, dirty and age bits in flip-flops, and the backing words in a RAM.
  // A dirty victim is written back in the same cycle as the new line is
  // filled, since the fill data was already read alongside the set.
  sawc_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (q_valid),
    .q_head  (q_head),
    .q_pop   (q_pop),
    .out_ch  (out_ch),
    .stat    (back_stat)
  );

`ifndef SYNTHESIS
  // The back stage only takes an item when it is idle and one is queued.
  a_pop_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> (q_valid && back_stat.idle))
    else $error("queue popped while empty or while busy");

  // The queue never holds more than its depth.
  a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (front_stat.count == sawc_pkg::QCNT_W'(0)) ||
    (front_stat.count == sawc_pkg::QCNT_W'(1)) ||
    (front_stat.count == sawc_pkg::QCNT_W'(2)))
    else $error("request queue overfilled");

  // A lookup is always followed by either its commit or a stall in place.
  a_lookup_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (back_stat.lookup && out_ch.ready) |=> back_stat.idle)
    else $error("lookup did not complete with a free response slot");
`endif

endmodule

`default_nettype wire
